[sv/afc_pkg.sv]
// Shared types, constants and helper functions for the ASCII frame checker.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package afc_pkg;

   // Payload store capacity in bytes.
   localparam int MAX_PAYLOAD = 16;
   localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   // Checksum nibble masks, most significant nibble first.
   localparam logic [15:0] NIBBLE_MASK [4] = '{16'hF000, 16'h0F00, 16'h00F0, 16'h000F};

   // Parser and drain phases.
   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_ID      = 7'b0000010,
      PH_LEN_HI  = 7'b0000100,
      PH_LEN_LO  = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_CHECK   = 7'b0100000,
      PH_DRAIN   = 7'b1000000
   } phase_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_DATA     = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_MISMATCH = 2'd2,
      ST_TOO_LONG = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      status_type status;
      logic       last;
   } rsp_type;

   // Write port of the payload store.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } mem_wr_type;

   // Decimal digit value; anything else counts as zero.
   function automatic logic [3:0] digit_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) begin
         return 4'(c - 8'h30);
      end
      return 4'd0;
   endfunction

   // Lowercase hex character for a nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return 8'h30 + 8'(n);
      end
      return 8'h61 + 8'(n) - 8'd10;
   endfunction

endpackage

`default_nettype wire

[sv/ascii_frame_checker.sv]
// Top level of the ASCII frame checker: parser/sequencer plus payload store.
// Depends on afc_pkg, afc_store and afc_ctrl.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   afc_pkg::req_type (byte_in, frame_start)
//   rsp_      out        rsp_valid / rsp_ready   afc_pkg::rsp_type (data_byte, status, last)
//
// One byte is taken per cycle while the frame is parsed.
// A good frame is drained one byte per cycle while the output register is free,
// from the store's single registered read port; req_ready is low meanwhile.
// A status result waits in the output register; the final checksum byte of
// the next frame stalls only if that register is still full.
// reset is synchronous and returns the parser to idle with no result pending.
`default_nettype none

module ascii_frame_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire afc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output afc_pkg::rsp_type      rsp_data
);

   afc_pkg::mem_wr_type          mem_wr;
   logic [afc_pkg::ADDR_W-1:0]   rd_addr;
   logic [7:0]                   rd_data;

   afc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .mem_wr    (mem_wr),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   afc_store u_store (
      .clock   (clock),
      .mem_wr  (mem_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

[sv/afc_store.sv]
// Payload store: one write port, one registered read port.
// Depends on afc_pkg for the depth, address width and write struct.
`default_nettype none

module afc_store (
   input  wire logic                      clock,
   input  wire afc_pkg::mem_wr_type       mem_wr,
   input  wire logic [afc_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                     rd_data
);

   logic [7:0] mem [afc_pkg::MAX_PAYLOAD];
   logic [7:0] rd_data_ff;

   // Write payload bytes, read one byte per cycle.
   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem[mem_wr.addr] <= mem_wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/afc_ctrl.sv]
// Frame parser and drain sequencer with the shared position counter,
// checksum adder and nibble compare. Depends on afc_pkg; drives afc_store.
`default_nettype none

module afc_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire afc_pkg::req_type          req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output afc_pkg::rsp_type               rsp_data,
   output afc_pkg::mem_wr_type            mem_wr,
   output logic [afc_pkg::ADDR_W-1:0]     rd_addr,
   input  wire logic [7:0]                rd_data
);

   afc_pkg::phase_type phase_ff, phase_in;
   logic [6:0]         position_ff, position_in;
   logic [6:0]         frame_length_ff, frame_length_in;
   logic [15:0]        running_sum_ff, running_sum_in;
   logic               mismatch_ff, mismatch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   afc_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        out_free;
   logic        check_final;
   logic [6:0]  pos_inc;
   logic [3:0]  digit;
   logic [1:0]  chk_idx;
   logic [3:0]  shamt;
   logic [15:0] masked;
   logic [3:0]  nib;
   logic        nib_bad;
   logic        bad_final;

   // Shared position increment, checksum nibble select and compare.
   assign pos_inc     = position_ff + 7'd1;
   assign digit       = afc_pkg::digit_value(req_data.byte_in);
   assign chk_idx     = position_ff[1:0];
   assign shamt       = 4'd12 - {chk_idx, 2'b00};
   assign masked      = (running_sum_ff & afc_pkg::NIBBLE_MASK[chk_idx]) >> shamt;
   assign nib         = masked[3:0];
   assign nib_bad     = afc_pkg::hex_char(nib) != req_data.byte_in;
   assign bad_final   = mismatch_ff | nib_bad;

   // Hold off only while draining, or when the final checksum byte finds the output register full.
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign check_final = (phase_ff == afc_pkg::PH_CHECK) && (position_ff == 7'd3);
   assign req_ready   = (phase_ff != afc_pkg::PH_DRAIN) && !(check_final && !out_free);
   assign accept      = req_valid && req_ready;

   // Next-state logic.
   always_comb begin
      phase_in        = phase_ff;
      position_in     = position_ff;
      frame_length_in = frame_length_ff;
      running_sum_in  = running_sum_ff;
      mismatch_in     = mismatch_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      mem_wr          = '0;

      if (accept && req_data.frame_start) begin
         // Restart parsing on a frame_start byte.
         phase_in        = afc_pkg::PH_ID;
         position_in     = 7'd0;
         frame_length_in = 7'd0;
         running_sum_in  = 16'd0;
         mismatch_in     = 1'b0;
      end else begin
         unique case (phase_ff)
            afc_pkg::PH_IDLE: begin
            end
            afc_pkg::PH_ID: begin
               if (accept) begin
                  phase_in = afc_pkg::PH_LEN_HI;
               end
            end
            afc_pkg::PH_LEN_HI: begin
               if (accept) begin
                  frame_length_in = 7'({digit, 3'b000}) + 7'({digit, 1'b0});
                  phase_in        = afc_pkg::PH_LEN_LO;
               end
            end
            afc_pkg::PH_LEN_LO: begin
               if (accept) begin
                  frame_length_in = frame_length_ff + 7'(digit);
                  position_in     = 7'd0;
                  phase_in        = (frame_length_in != 7'd0) ? afc_pkg::PH_PAYLOAD
                                                              : afc_pkg::PH_CHECK;
               end
            end
            afc_pkg::PH_PAYLOAD: begin
               if (accept) begin
                  // Store the byte if it fits, always add it to the sum.
                  mem_wr.en      = position_ff < 7'(afc_pkg::MAX_PAYLOAD);
                  mem_wr.addr    = position_ff[afc_pkg::ADDR_W-1:0];
                  mem_wr.data    = req_data.byte_in;
                  running_sum_in = running_sum_ff + 16'(req_data.byte_in);
                  position_in    = pos_inc;
                  if (pos_inc >= frame_length_ff) begin
                     position_in = 7'd0;
                     phase_in    = afc_pkg::PH_CHECK;
                  end
               end
            end
            afc_pkg::PH_CHECK: begin
               if (accept) begin
                  mismatch_in = bad_final;
                  position_in = pos_inc;
                  if (check_final) begin
                     position_in = 7'd0;
                     phase_in    = afc_pkg::PH_IDLE;
                     rsp_data_in.data_byte = 8'd0;
                     rsp_data_in.last      = 1'b1;
                     if (frame_length_ff > 7'(afc_pkg::MAX_PAYLOAD)) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = afc_pkg::ST_TOO_LONG;
                     end else if (bad_final) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = afc_pkg::ST_MISMATCH;
                     end else if (frame_length_ff == 7'd0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = afc_pkg::ST_EMPTY;
                     end else begin
                        phase_in = afc_pkg::PH_DRAIN;
                     end
                  end
               end
            end
            afc_pkg::PH_DRAIN: begin
               // Advance through the store one byte per free output slot.
               if (out_free) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.data_byte = rd_data;
                  rsp_data_in.status    = afc_pkg::ST_DATA;
                  rsp_data_in.last      = pos_inc == frame_length_ff;
                  position_in           = pos_inc;
                  if (pos_inc == frame_length_ff) begin
                     position_in = 7'd0;
                     phase_in    = afc_pkg::PH_IDLE;
                  end
               end
            end
            default: begin
               phase_in = afc_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Read the entry the next cycle will drain, so data is always ready.
   assign rd_addr = position_in[afc_pkg::ADDR_W-1:0];

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= afc_pkg::PH_IDLE;
         position_ff     <= 7'd0;
         frame_length_ff <= 7'd0;
         running_sum_ff  <= 16'd0;
         mismatch_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         position_ff     <= position_in;
         frame_length_ff <= frame_length_in;
         running_sum_ff  <= running_sum_in;
         mismatch_ff     <= mismatch_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
